// ===== rtl/core/wvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed velocity statistics package
// Shared widths, defaults, register indexes, record types and a helper function.
// ----------------------------------------------------------------------------
package wvs_pkg;

  localparam int VEL_W      = 16;
  localparam int SUM_W      = 24;
  localparam int CNT_W      = 8;
  localparam int POS_W      = 8;
  localparam int MEAN_W     = 24;
  localparam int FRAC_BITS  = 8;
  localparam int DIV_W      = SUM_W + FRAC_BITS;
  localparam int MAG_W      = VEL_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FIFO_DEPTH = 2;
  localparam int MAX_CELLS  = 128;

  localparam logic [POS_W-1:0] DEFAULT_START = POS_W'(1);
  localparam logic [POS_W-1:0] DEFAULT_END   = POS_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CELL  = 2'd0,
    REG_END_CELL    = 2'd1,
    REG_LOWER_BOUND = 2'd2,
    REG_UPPER_BOUND = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        [POS_W-1:0] start_cell;
    logic        [POS_W-1:0] end_cell;
    logic signed [VEL_W-1:0] lower_bound;
    logic signed [VEL_W-1:0] upper_bound;
  } cfg_t;

  // Statistics of one finished profile, handed from the front to the back.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic        [CNT_W-1:0] count;
    logic signed [VEL_W-1:0] min_vel;
    logic signed [VEL_W-1:0] max_vel;
  } rec_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_OUT
  } div_state_t;

  // Magnitude of a velocity; the most negative value maps to 32768.
  function automatic logic [MAG_W-1:0] vel_mag(input logic signed [VEL_W-1:0] v);
    logic signed [MAG_W-1:0] ext;
    ext = MAG_W'(v);
    return v[VEL_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wvs_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell input channel
// Valid/ready channel carrying one profile cell per transfer.
// ----------------------------------------------------------------------------
interface wvs_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [wvs_pkg::VEL_W-1:0] velocity;
  logic                            last_cell;

  modport source (output valid, velocity, last_cell, input ready);
  modport sink   (input valid, velocity, last_cell, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wvs_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying the statistics of one profile per transfer.
// ----------------------------------------------------------------------------
interface wvs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [wvs_pkg::MEAN_W-1:0] mean_q8;
  logic signed [wvs_pkg::VEL_W-1:0]  min_velocity;
  logic signed [wvs_pkg::VEL_W-1:0]  max_velocity;
  logic        [wvs_pkg::CNT_W-1:0]  valid_count;

  modport source (output valid, mean_q8, min_velocity, max_velocity, valid_count,
                  input ready);
  modport sink   (input valid, mean_q8, min_velocity, max_velocity, valid_count,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wvs_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface wvs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wvs_pkg::CFG_IDX_W-1:0]     index;
  logic [wvs_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/wvs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Profile accumulator
// Numbers incoming cells, gates them by window and bounds, and keeps the
// running sum, count and extreme-magnitude values of the current profile.
// ----------------------------------------------------------------------------
module wvs_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wvs_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  input  logic signed [wvs_pkg::VEL_W-1:0] in_velocity,
  input  logic                             in_last,
  output logic                             in_ready,
  output logic                             push,
  output wvs_pkg::rec_t                    push_rec,
  input  logic                             full
);

  logic        [wvs_pkg::POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic signed [wvs_pkg::SUM_W-1:0] sum_r, sum_nxt, sum_upd;
  logic        [wvs_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic signed [wvs_pkg::VEL_W-1:0] min_r, min_nxt, min_upd;
  logic signed [wvs_pkg::VEL_W-1:0] max_r, max_nxt, max_upd;
  logic                             seeded_r, seeded_nxt;
  logic        [wvs_pkg::POS_W-1:0] first_pos, final_pos;
  logic        [wvs_pkg::MAG_W-1:0] mag_v;
  logic                             in_window, in_bounds, counted, accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && in_last;

  always_comb begin
    pos_inc   = (pos_r == '1) ? pos_r : pos_r + 1'b1;
    first_pos = (cfg.start_cell == '0) ? wvs_pkg::DEFAULT_START : cfg.start_cell;
    final_pos = (cfg.end_cell == '0) ? wvs_pkg::DEFAULT_END : cfg.end_cell;
    in_window = (pos_inc >= first_pos) && (pos_inc <= final_pos) &&
                (pos_inc <= wvs_pkg::POS_W'(wvs_pkg::MAX_CELLS));
    in_bounds = ($signed(in_velocity) >= $signed(cfg.lower_bound)) &&
                ($signed(in_velocity) <= $signed(cfg.upper_bound));
    counted   = in_window && in_bounds;
    mag_v     = wvs_pkg::vel_mag(in_velocity);

    sum_upd = sum_r;
    cnt_upd = cnt_r;
    min_upd = min_r;
    max_upd = max_r;
    if (counted) begin
      sum_upd = sum_r + wvs_pkg::SUM_W'(in_velocity);
      cnt_upd = cnt_r + 1'b1;
      // The first counted cell seeds both extremes; ties keep the earlier value.
      if (!seeded_r || (mag_v < wvs_pkg::vel_mag(min_r))) begin
        min_upd = in_velocity;
      end
      if (!seeded_r || (mag_v > wvs_pkg::vel_mag(max_r))) begin
        max_upd = in_velocity;
      end
    end

    push_rec.sum     = sum_upd;
    push_rec.count   = cnt_upd;
    push_rec.min_vel = min_upd;
    push_rec.max_vel = max_upd;

    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    seeded_nxt = seeded_r;
    if (accept) begin
      if (in_last) begin
        pos_nxt    = '0;
        sum_nxt    = '0;
        cnt_nxt    = '0;
        min_nxt    = '0;
        max_nxt    = '0;
        seeded_nxt = 1'b0;
      end else begin
        pos_nxt    = pos_inc;
        sum_nxt    = sum_upd;
        cnt_nxt    = cnt_upd;
        min_nxt    = min_upd;
        max_nxt    = max_upd;
        seeded_nxt = seeded_r || counted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      min_r    <= '0;
      max_r    <= '0;
      seeded_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      seeded_r <= seeded_nxt;
    end
  end

  a_count_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pos_r)
    else $error("counted cells exceed the cell position");

  a_seeded_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r == (cnt_r != '0))
    else $error("seed flag disagrees with the counted cells");

endmodule
`default_nettype wire

// ===== rtl/core/wvs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Profile record queue
// Short first-in first-out queue of finished profile records between the
// accumulator and the divider.
// ----------------------------------------------------------------------------
module wvs_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wvs_pkg::rec_t push_rec,
  output logic          full,
  input  logic          pop,
  output wvs_pkg::rec_t pop_rec,
  output logic          empty
);

  localparam int PTR_W = (wvs_pkg::FIFO_DEPTH > 1) ? $clog2(wvs_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(wvs_pkg::FIFO_DEPTH + 1);

  wvs_pkg::rec_t    slot_r [wvs_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full    = (fill_r == CNT_W'(wvs_pkg::FIFO_DEPTH));
  assign empty   = (fill_r == '0);
  assign pop_rec = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(wvs_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(wvs_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    fill_nxt = fill_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("record written into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("record read from an empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/wvs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mean divider and result register
// Takes one profile record at a time, divides the scaled sum by the count
// with a bit-serial restoring divider, and holds the result for transfer.
// ----------------------------------------------------------------------------
module wvs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wvs_pkg::rec_t                     pop_rec,
  input  logic                              empty,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [wvs_pkg::MEAN_W-1:0] out_mean_q8,
  output logic signed [wvs_pkg::VEL_W-1:0]  out_min_velocity,
  output logic signed [wvs_pkg::VEL_W-1:0]  out_max_velocity,
  output logic        [wvs_pkg::CNT_W-1:0]  out_valid_count
);

  localparam int STEP_W = $clog2(wvs_pkg::DIV_W);

  wvs_pkg::div_state_t state_r, state_nxt;
  logic [wvs_pkg::DIV_W-1:0]       dvd_r, dvd_nxt;
  logic [wvs_pkg::CNT_W-1:0]       rem_r, rem_nxt;
  logic [wvs_pkg::CNT_W-1:0]       dvs_r, dvs_nxt;
  logic [STEP_W-1:0]               step_r, step_nxt;
  logic                            neg_r, neg_nxt;
  logic signed [wvs_pkg::MEAN_W-1:0] mean_r, mean_nxt;
  logic signed [wvs_pkg::VEL_W-1:0]  min_r, min_nxt;
  logic signed [wvs_pkg::VEL_W-1:0]  max_r, max_nxt;
  logic        [wvs_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [wvs_pkg::CNT_W:0]         rem_sh;
  logic [wvs_pkg::SUM_W-1:0]       abs_sum;
  logic [wvs_pkg::MEAN_W-1:0]      quo;
  logic                            q_bit;

  assign out_valid        = (state_r == wvs_pkg::DIV_OUT);
  assign out_mean_q8      = mean_r;
  assign out_min_velocity = min_r;
  assign out_max_velocity = max_r;
  assign out_valid_count  = cnt_r;

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    mean_nxt  = mean_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    cnt_nxt   = cnt_r;
    pop       = 1'b0;

    abs_sum = pop_rec.sum[wvs_pkg::SUM_W-1] ? wvs_pkg::SUM_W'(-pop_rec.sum)
                                            : wvs_pkg::SUM_W'(pop_rec.sum);

    // One quotient bit per cycle: shift the next dividend bit into the
    // remainder and subtract the count when it fits.
    rem_sh = {rem_r, dvd_r[wvs_pkg::DIV_W-1]};
    q_bit  = (rem_sh >= {1'b0, dvs_r});
    quo    = '0;

    unique case (state_r)
      wvs_pkg::DIV_IDLE: begin
        if (!empty) begin
          pop      = 1'b1;
          dvd_nxt  = {abs_sum, {wvs_pkg::FRAC_BITS{1'b0}}};
          rem_nxt  = '0;
          dvs_nxt  = pop_rec.count;
          neg_nxt  = pop_rec.sum[wvs_pkg::SUM_W-1];
          step_nxt = '0;
          min_nxt  = pop_rec.min_vel;
          max_nxt  = pop_rec.max_vel;
          cnt_nxt  = pop_rec.count;
          if (pop_rec.count == '0) begin
            mean_nxt  = '0;
            state_nxt = wvs_pkg::DIV_OUT;
          end else begin
            state_nxt = wvs_pkg::DIV_RUN;
          end
        end
      end
      wvs_pkg::DIV_RUN: begin
        rem_nxt = q_bit ? wvs_pkg::CNT_W'(rem_sh - {1'b0, dvs_r})
                        : wvs_pkg::CNT_W'(rem_sh);
        dvd_nxt = {dvd_r[wvs_pkg::DIV_W-2:0], q_bit};
        if (step_r == STEP_W'(wvs_pkg::DIV_W - 1)) begin
          quo       = dvd_nxt[wvs_pkg::MEAN_W-1:0];
          mean_nxt  = neg_r ? wvs_pkg::MEAN_W'(-quo) : wvs_pkg::MEAN_W'(quo);
          step_nxt  = '0;
          state_nxt = wvs_pkg::DIV_OUT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      wvs_pkg::DIV_OUT: begin
        if (out_ready) begin
          state_nxt = wvs_pkg::DIV_IDLE;
        end
      end
      default: begin
        state_nxt = wvs_pkg::DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wvs_pkg::DIV_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
    mean_r <= mean_nxt;
    min_r  <= min_nxt;
    max_r  <= max_nxt;
    cnt_r  <= cnt_nxt;
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wvs_pkg::DIV_RUN) |-> (rem_r < dvs_r))
    else $error("division remainder not below the divisor");

  a_step_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != wvs_pkg::DIV_RUN) |-> (step_r == '0))
    else $error("division step counter left running");

endmodule
`default_nettype wire

// ===== rtl/core/windowed_velocity_statistics.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed velocity statistics
// Range-gated mean, count and smallest/largest-magnitude velocity per profile.
// ----------------------------------------------------------------------------
// Cells of a profile arrive on in_cell, one per transfer, the final cell
// flagged by last_cell. The accumulator takes one cell per cycle while the
// queue is not full. On the last cell it closes the profile into a record
// and pushes it into a two-entry queue; the divider pops one record at a
// time, computes sum * 256 / count one quotient bit per cycle, and presents
// the result on out_res before it takes the next record.
// Cells keep flowing while the queue has room; back-to-back profiles shorter
// than the divider time fill the queue and then hold in_cell.ready low.
// A result stays on out_res until the receiver takes it; while it waits the
// divider holds and further records wait in the queue.
// Registers are written through cfg_wr, which is always ready; write them
// only while no profile is in flight.
// Reset restores the register defaults (window 1 to 10, full velocity range)
// and empties the accumulator, queue and divider.
// ----------------------------------------------------------------------------
module windowed_velocity_statistics (
  input  logic           clk,
  input  logic           rst_n,
  wvs_in_if.sink         in_cell,
  wvs_out_if.source      out_res,
  wvs_cfg_if.sink        cfg_wr
);

  wvs_pkg::cfg_t cfg_r;
  wvs_pkg::rec_t push_rec, pop_rec;
  logic          push, pop, full, empty;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_cell  <= wvs_pkg::DEFAULT_START;
      cfg_r.end_cell    <= wvs_pkg::DEFAULT_END;
      cfg_r.lower_bound <= {1'b1, {(wvs_pkg::VEL_W-1){1'b0}}};
      cfg_r.upper_bound <= {1'b0, {(wvs_pkg::VEL_W-1){1'b1}}};
    end else if (cfg_wr.valid) begin
      unique case (wvs_pkg::cfg_reg_t'(cfg_wr.index))
        wvs_pkg::REG_START_CELL:  cfg_r.start_cell  <= cfg_wr.data[wvs_pkg::POS_W-1:0];
        wvs_pkg::REG_END_CELL:    cfg_r.end_cell    <= cfg_wr.data[wvs_pkg::POS_W-1:0];
        wvs_pkg::REG_LOWER_BOUND: cfg_r.lower_bound <= cfg_wr.data[wvs_pkg::VEL_W-1:0];
        wvs_pkg::REG_UPPER_BOUND: cfg_r.upper_bound <= cfg_wr.data[wvs_pkg::VEL_W-1:0];
      endcase
    end
  end

  wvs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_cell.valid),
    .in_velocity (in_cell.velocity),
    .in_last     (in_cell.last_cell),
    .in_ready    (in_cell.ready),
    .push        (push),
    .push_rec    (push_rec),
    .full        (full)
  );

  wvs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .empty    (empty)
  );

  wvs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_rec          (pop_rec),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_res.valid),
    .out_ready        (out_res.ready),
    .out_mean_q8      (out_res.mean_q8),
    .out_min_velocity (out_res.min_velocity),
    .out_max_velocity (out_res.max_velocity),
    .out_valid_count  (out_res.valid_count)
  );

endmodule
`default_nettype wire
